FILE: design/string_split_on_delimiter_top_defines.svh
// assertion macros shared by the string splitter rtl
`ifndef STRING_SPLIT_ON_DELIMITER_TOP_DEFINES_SVH
`define STRING_SPLIT_ON_DELIMITER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SSPLIT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define SSPLIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSPLIT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SSPLIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/ssplit_pkg.sv
// types and constants of the string splitter
package ssplit_pkg;

    // fixed field widths
    localparam int DELIM_W   = 64;
    localparam int DLEN_W    = 4;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b1;

    // window control from the segment logic
    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [7:0] data;
    } win_ctrl_t;

endpackage

FILE: design/string_split_on_delimiter_top.sv
// Streaming string splitter: one word in, zero or one segment descriptor out.
// Path: input register, window compare and position update, then result register.
// Throughput: 1 word per cycle unless the result register stalls.
// A stalled result register holds the input register, which holds s_ready low.
// Reset (synchronous, active low) clears the window, positions, registers and valids.
`include "string_split_on_delimiter_top_defines.svh"
module string_split_on_delimiter_top
    import ssplit_pkg::*;
#(
    parameter int MAX_DELIMITER = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELIM_W-1:0]   cfg_wdata,
    // input words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_last_byte,
    input  logic                 s_empty_string,
    // segment descriptors
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_segment_start,
    output logic [OUT_W-1:0]     m_segment_length,
    output logic                 m_last_segment
);

    localparam int LEN_W = $clog2(MAX_DELIMITER + 1);
    localparam int POS_W = POSITION_BITS;
    localparam logic [DLEN_W-1:0] MAX_LEN = DLEN_W'(MAX_DELIMITER);

    // configuration registers
    logic [DELIM_W-1:0] delim_bytes_reg;
    logic [DLEN_W-1:0]  delim_len_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // string state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] seg_start_reg, seg_start_next;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_start_reg, m_start_next;
    logic [OUT_W-1:0] m_length_reg, m_length_next;
    logic             m_last_reg, m_last_next;

    logic             advance;
    logic             has_result;
    logic             take;
    logic             match;
    logic [DLEN_W-1:0] len_clamp;
    logic [LEN_W-1:0] eff_len;
    logic [POS_W-1:0] eff_len_pos;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] res_start;
    logic [POS_W-1:0] res_len;
    logic [POS_W+OUT_W-1:0] start_wide;
    logic [POS_W+OUT_W-1:0] len_wide;
    win_ctrl_t        win_ctrl;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_bytes_reg <= '0;
            delim_len_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DELIM_BYTES:  delim_bytes_reg <= cfg_wdata;
                REG_DELIM_LENGTH: delim_len_reg   <= cfg_wdata[DLEN_W-1:0];
            endcase
        end
    end

    // handshake: the input register moves on when the result register can take it
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_data_byte;
            in_last_reg  <= s_last_byte;
            in_empty_reg <= s_empty_string;
        end
    end

    // effective delimiter length, clamped to the window depth
    assign len_clamp   = (delim_len_reg > MAX_LEN) ? MAX_LEN : delim_len_reg;
    assign eff_len     = len_clamp[LEN_W-1:0];
    assign eff_len_pos = POS_W'(eff_len);

    // window and compare
    assign win_ctrl.shift = advance && !in_empty_reg;
    assign win_ctrl.clear = advance && (in_last_reg || in_empty_reg);
    assign win_ctrl.data  = in_byte_reg;

    ssplit_window #(
        .MAX_DELIMITER (MAX_DELIMITER),
        .LEN_W         (LEN_W)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (win_ctrl),
        .delim_bytes (delim_bytes_reg),
        .delim_len   (eff_len),
        .match       (match)
    );

    // segment decision for the word in the input register
    assign end_pos = (pos_reg != '1) ? pos_reg + POS_W'(1) : pos_reg;
    assign take    = (eff_len != '0) && (end_pos >= eff_len_pos)
                     && ((end_pos - eff_len_pos) >= seg_start_reg) && match;

    always_comb begin
        has_result     = 1'b0;
        res_start      = seg_start_reg;
        res_len        = '0;
        m_last_next    = 1'b1;
        pos_next       = pos_reg;
        seg_start_next = seg_start_reg;
        priority if (in_empty_reg) begin
            has_result     = 1'b1;
            res_start      = '0;
            pos_next       = '0;
            seg_start_next = '0;
        end else if (take) begin
            has_result  = 1'b1;
            res_len     = end_pos - eff_len_pos - seg_start_reg;
            m_last_next = in_last_reg;
            if (in_last_reg) begin
                pos_next       = '0;
                seg_start_next = '0;
            end else begin
                pos_next       = end_pos;
                seg_start_next = end_pos;
            end
        end else if (in_last_reg) begin
            has_result     = 1'b1;
            res_len        = end_pos - seg_start_reg;
            pos_next       = '0;
            seg_start_next = '0;
        end else begin
            pos_next = end_pos;
        end
    end

    // report positions in the low bits of the output fields
    assign start_wide    = {{OUT_W{1'b0}}, res_start};
    assign len_wide      = {{OUT_W{1'b0}}, res_len};
    assign m_start_next  = start_wide[OUT_W-1:0];
    assign m_length_next = len_wide[OUT_W-1:0];

    // string state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            seg_start_reg <= '0;
        end else if (advance) begin
            pos_reg       <= pos_next;
            seg_start_reg <= seg_start_next;
        end
    end

    // result register
    assign m_valid_next = (advance && has_result) ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            m_start_reg  <= m_start_next;
            m_length_reg <= m_length_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_segment_start  = m_start_reg;
    assign m_segment_length = m_length_reg;
    assign m_last_segment   = m_last_reg;

    // checks
    `SSPLIT_ASSERT_NEXT(a_end_clears, aclk, aresetn, advance && (in_last_reg || in_empty_reg), pos_reg == '0 && seg_start_reg == '0, "string end did not clear positions")
    `SSPLIT_ASSERT_SAME(a_seg_order, aclk, aresetn, 1'b1, seg_start_reg <= pos_reg, "open segment starts past current position")
    `SSPLIT_ASSERT_NEXT(a_result_load, aclk, aresetn, advance && has_result, m_valid_reg, "result not presented")
    `SSPLIT_ASSERT_SAME(a_end_result, aclk, aresetn, in_valid_reg && (in_last_reg || in_empty_reg), has_result, "string end without a segment")

endmodule

FILE: design/ssplit_window.sv
// recent-byte window and parallel delimiter compare
module ssplit_window
    import ssplit_pkg::*;
#(
    parameter int MAX_DELIMITER = 8,
    parameter int LEN_W         = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  win_ctrl_t          ctrl,
    input  logic [DELIM_W-1:0] delim_bytes,
    input  logic [LEN_W-1:0]   delim_len,
    output logic               match
);

    logic [7:0]               win_reg [MAX_DELIMITER];
    logic [7:0]               win_next [MAX_DELIMITER];
    logic [MAX_DELIMITER-1:0] eq [MAX_DELIMITER];
    logic [MAX_DELIMITER-1:0] len_hit;

    // window as it stands once the new byte is shifted in
    for (genvar g = 0; g < MAX_DELIMITER; g++) begin : g_lane
        if (g == 0) begin : g_head
            assign win_next[g] = ctrl.data;
        end else begin : g_tail
            assign win_next[g] = win_reg[g-1];
        end
    end

    // per-length compare: length k+1 checks delimiter byte i against lane k-i
    for (genvar k = 0; k < MAX_DELIMITER; k++) begin : g_len
        for (genvar i = 0; i < MAX_DELIMITER; i++) begin : g_byte
            if (i <= k) begin : g_used
                assign eq[k][i] = (win_next[k-i] == delim_bytes[8*i +: 8]);
            end else begin : g_unused
                assign eq[k][i] = 1'b1;
            end
        end
        assign len_hit[k] = &eq[k];
    end

    // pick the compare for the active length
    always_comb begin
        match = 1'b0;
        for (int k = 0; k < MAX_DELIMITER; k++) begin
            if (delim_len == LEN_W'(k + 1)) begin
                match = len_hit[k];
            end
        end
    end

    // window register
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int k = 0; k < MAX_DELIMITER; k++) begin
                win_reg[k] <= 8'h00;
            end
        end else if (ctrl.shift) begin
            win_reg <= win_next;
        end
    end

endmodule

FILE: bench/tb_string_split_on_delimiter_top.sv
// testbench for the string splitter: generated strings checked against a segment predictor
`timescale 1ns / 1ps

module tb_string_split_on_delimiter_top;
    import ssplit_pkg::*;

    localparam int MAX_DELIM    = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 1100;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } word_t;

    typedef struct packed {
        logic [OUT_W-1:0] start;
        logic [OUT_W-1:0] length;
        logic             last;
    } seg_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DELIM_W-1:0]   cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic                 s_empty_string = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_W-1:0]     m_segment_start;
    logic [OUT_W-1:0]     m_segment_length;
    logic                 m_last_segment;

    string_split_on_delimiter_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .s_empty_string   (s_empty_string),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_segment_start  (m_segment_start),
        .m_segment_length (m_segment_length),
        .m_last_segment   (m_last_segment)
    );

    always #5 aclk = ~aclk;

    // stimulus side
    word_t          pending_words[$];
    int             words_queued = 0;
    int             strings_sent = 0;
    int             settings_used = 0;
    int             gap_max = 0;
    rx_mode_t       rx_mode = RX_ALWAYS;
    int             hold_requests = 0;
    logic [63:0]    cur_delim = '0;
    int             cur_n = 0;

    // predictor state and expected segments
    logic [7:0]         win_bytes [MAX_DELIM];
    logic [15:0]        pos_next;
    logic [15:0]        seg_open;
    logic [DELIM_W-1:0] delim_cfg;
    logic [DLEN_W-1:0]  dlen_cfg;
    seg_t               seg_q[$];
    int                 words_accepted = 0;
    int                 segs_checked = 0;
    int                 err_count = 0;

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    task automatic clear_string;
        for (int i = 0; i < MAX_DELIM; i++) win_bytes[i] = 8'h00;
        pos_next = '0;
        seg_open = '0;
    endtask

    // one accepted word through the splitter predictor
    task automatic split_step(input word_t w);
        int   n;
        int   endp;
        bit   hit;
        seg_t s;
        n = (dlen_cfg > MAX_DELIM) ? MAX_DELIM : int'(dlen_cfg);
        if (w.empty) begin
            clear_string();
            s = '{start: '0, length: '0, last: 1'b1};
            seg_q = {seg_q, s};
        end else begin
            for (int i = MAX_DELIM - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
            win_bytes[0] = w.data;
            endp = (pos_next != 16'hFFFF) ? int'(pos_next) + 1 : 16'hFFFF;
            pos_next = endp[15:0];
            hit = (n > 0) && (endp >= n) && (endp - n >= int'(seg_open));
            for (int i = 0; i < n; i++)
                if (win_bytes[n-1-i] != delim_cfg[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                s.start  = seg_open;
                s.length = 16'(endp - n - int'(seg_open));
                s.last   = w.last;
                seg_q = {seg_q, s};
                if (w.last) clear_string();
                else seg_open = endp[15:0];
            end else if (w.last) begin
                s.start  = seg_open;
                s.length = 16'(endp - int'(seg_open));
                s.last   = 1'b1;
                seg_q = {seg_q, s};
                clear_string();
            end
        end
    endtask

    // driver: bursts of words with random gaps
    int    burst_left = 0;
    int    gap_left = 0;
    word_t drv_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                drv_word = pending_words.pop_front();
                s_valid        <= 1'b1;
                s_data_byte    <= drv_word.data;
                s_last_byte    <= drv_word.last;
                s_empty_string <= drv_word.empty;
                if (burst_left == 0) burst_left = $urandom_range(1, 24);
                burst_left--;
                if (burst_left == 0 && gap_max > 0) gap_left = $urandom_range(0, gap_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus long hold-offs on request
    int hold_left = 0;
    int holds_served = 0;
    int rx_cycle = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else begin
            rx_cycle++;
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_RANDOM:   m_ready <= 1'($urandom);
                    RX_PERIODIC: m_ready <= (rx_cycle % 11) < 7;
                    default:     m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // monitor: track config, predict on input words, check segments
    seg_t got_seg;
    seg_t want_seg;

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_string();
            delim_cfg = '0;
            dlen_cfg  = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DELIM_BYTES:  delim_cfg = cfg_wdata;
                    REG_DELIM_LENGTH: dlen_cfg  = cfg_wdata[DLEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                split_step('{data: s_data_byte, last: s_last_byte, empty: s_empty_string});
                words_accepted++;
            end
            if (m_valid && m_ready) begin
                got_seg = '{start: m_segment_start, length: m_segment_length,
                            last: m_last_segment};
                if (seg_q.size() == 0) begin
                    report($sformatf("unexpected segment start %0d length %0d last %0b",
                                     got_seg.start, got_seg.length, got_seg.last));
                end else begin
                    want_seg = seg_q.pop_front();
                    if (got_seg.start !== want_seg.start)
                        report($sformatf("segment %0d start got %0d expected %0d",
                                         segs_checked, got_seg.start, want_seg.start));
                    if (got_seg.length !== want_seg.length)
                        report($sformatf("segment %0d length got %0d expected %0d",
                                         segs_checked, got_seg.length, want_seg.length));
                    if (got_seg.last !== want_seg.last)
                        report($sformatf("segment %0d last got %0b expected %0b",
                                         segs_checked, got_seg.last, want_seg.last));
                end
                segs_checked++;
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
                $display("string_split_on_delimiter_top test failed");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [7:0] data, input logic last, input logic empty);
        word_t w;
        w = '{data: data, last: last, empty: empty};
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    // string of the given length built from delimiter pieces and noise bytes
    task automatic push_string(input int len);
        int         k;
        logic [7:0] b;
        strings_sent++;
        if (len == 0) begin
            push_word(8'($urandom), 1'($urandom), 1'b1);
        end else begin
            k = 0;
            while (k < len) begin
                if ($urandom_range(0, 59) == 0) begin
                    // empty flag in mid-string drops the partial string
                    push_word(8'($urandom), 1'($urandom), 1'b1);
                    k = len;
                end else if (cur_n > 0 && k + cur_n <= len && $urandom_range(0, 3) == 0) begin
                    for (int j = 0; j < cur_n; j++)
                        push_word(cur_delim[8*j +: 8], k + j + 1 == len, 1'b0);
                    k += cur_n;
                end else begin
                    if ($urandom_range(0, 2) == 0) b = 8'($urandom);
                    else b = cur_delim[8*$urandom_range(0, 7) +: 8];
                    push_word(b, k + 1 == len, 1'b0);
                    k++;
                end
            end
        end
    endtask

    task automatic wait_idle;
        while (words_accepted != words_queued || seg_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register writes only with the block drained
    task automatic set_delimiter(input logic [63:0] bytes, input logic [DLEN_W-1:0] len);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DELIM_BYTES;
        cfg_wdata <= bytes;
        @(posedge aclk);
        cfg_index <= REG_DELIM_LENGTH;
        cfg_wdata <= DELIM_W'(len);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_delim = bytes;
        cur_n     = (len > MAX_DELIM) ? MAX_DELIM : int'(len);
        settings_used++;
    endtask

    initial begin
        int          lens [12];
        int          phase;
        int          nstr;
        int          slen;
        int          random_start;
        logic [63:0] bytes;
        logic [3:0]  dlen;
        logic [7:0]  b;

        lens = '{1, 2, 3, 8, 0, 15, 9, 4, 5, 6, 7, 12};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        gap_max <= 3;
        rx_mode <= RX_RANDOM;

        // no delimiter: whole string, empty string, one-byte string
        set_delimiter(64'h0, 4'd0);
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);
        push_word(8'h41, 1'b0, 1'b0);
        push_word(8'h42, 1'b1, 1'b0);

        // two-byte delimiter: leading and middle empty, delimiter at end, empty flag mid-string
        set_delimiter(64'h0000_0000_0000_FF00, 4'd2);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h7E, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'h55, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hAA, 1'b1, 1'b1);

        // overlong length clamps to eight bytes
        set_delimiter(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        for (int i = 0; i < 9; i++) push_word(8'hFF, i == 8, 1'b0);
        strings_sent += 6;

        // random phases over many delimiter settings
        random_start = words_queued;
        phase = 0;
        while (words_queued - random_start < RANDOM_WORDS) begin
            dlen = (phase < 12) ? lens[phase][3:0] : 4'($urandom);
            if (phase % 4 == 3) begin
                b = 8'($urandom);
                bytes = {8{b}};
            end else if (phase == 2) begin
                bytes = '0;
            end else begin
                bytes = {$urandom, $urandom};
            end
            set_delimiter(bytes, dlen);
            case (phase % 3)
                0: gap_max <= 0;
                1: gap_max <= 3;
                default: gap_max <= 12;
            endcase
            rx_mode <= rx_mode_t'(phase % 4);
            nstr = $urandom_range(8, 20);
            for (int s = 0; s < nstr; s++) begin
                if ($urandom_range(0, 9) == 0) slen = 0;
                else if ($urandom_range(0, 5) == 0) slen = $urandom_range(10, 40);
                else slen = $urandom_range(1, 8);
                push_string(slen);
            end
            if (phase == 3 || phase == 9) hold_requests <= hold_requests + 1;
            phase++;
        end

        wait_idle();
        if (seg_q.size() != 0) report($sformatf("%0d segments never arrived", seg_q.size()));
        $display("run covered %0d words in %0d strings under %0d delimiter settings",
                 words_queued, strings_sent, settings_used);
        $display("%0d segments checked across empty, leading, middle and final segments",
                 segs_checked);
        if (err_count == 0) begin
            $display("string_split_on_delimiter_top test passed");
        end else begin
            $display("string_split_on_delimiter_top test failed");
        end
        $finish;
    end

endmodule
